// ----- rtl/core/gdbrsp_pkg.sv -----
// Types, character constants and reply tables for the GDB remote-protocol
// packet receiver. No dependencies.
package gdbrsp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_S      = 8'h53;  // 'S'
  localparam logic [7:0] CH_LC_B   = 8'h62;  // 'b'
  localparam logic [7:0] CH_LC_C   = 8'h63;  // 'c'
  localparam logic [7:0] CH_QUERY  = 8'h3F;  // '?'
  localparam logic [7:0] CH_LC_M   = 8'h6D;  // 'm'
  localparam logic [7:0] CH_LC_G   = 8'h67;  // 'g'

  localparam logic [7:0] HEX_LC_BASE = 8'h57;  // 'a' - 10
  localparam logic [7:0] HEX_UC_BASE = 8'h37;  // 'A' - 10

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_BODY   = 2'd1,
    PH_CK_HI  = 2'd2,
    PH_CK_LO  = 2'd3
  } phase_t;

  // Reply that one input byte can trigger
  typedef enum logic [2:0] {
    RSP_NONE  = 3'd0,
    RSP_NACK  = 3'd1,
    RSP_EMPTY = 3'd2,
    RSP_S09   = 3'd3,
    RSP_MEM   = 3'd4,
    RSP_REG   = 3'd5
  } rsp_code_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_MEM  = 2'd1,
    KIND_REG  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic        valid;
    rsp_code_t   code;
    logic [31:0] addr;
    logic [31:0] len;
  } rsp_req_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c[6]) begin
      v = c[5] ? (c - HEX_LC_BASE) : (c - HEX_UC_BASE);
    end else begin
      v = c - CH_ZERO;
    end
    return v;
  endfunction

  function automatic logic [3:0] reply_len(input rsp_code_t code);
    logic [3:0] n;
    case (code)
      RSP_NACK:  n = 4'd1;
      RSP_EMPTY: n = 4'd5;
      RSP_S09:   n = 4'd8;
      RSP_MEM:   n = 4'd2;
      RSP_REG:   n = 4'd2;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_byte(input rsp_code_t code, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (code)
      RSP_NACK: b = CH_MINUS;
      RSP_EMPTY: begin
        case (idx)
          3'd0:    b = CH_PLUS;
          3'd1:    b = CH_DOLLAR;
          3'd2:    b = CH_HASH;
          default: b = CH_ZERO;
        endcase
      end
      RSP_S09: begin
        case (idx)
          3'd0:    b = CH_PLUS;
          3'd1:    b = CH_DOLLAR;
          3'd2:    b = CH_S;
          3'd3:    b = CH_ZERO;
          3'd4:    b = CH_NINE;
          3'd5:    b = CH_HASH;
          3'd6:    b = CH_LC_B;
          default: b = CH_LC_C;
        endcase
      end
      RSP_MEM, RSP_REG: b = (idx == 3'd0) ? CH_PLUS : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/gdbrsp_if.sv -----
// Valid/ready channel interfaces for the packet receiver: received bytes in,
// reply items out. No dependencies.
interface gdbrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gdbrsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic [1:0]  cmd_kind;
  logic [31:0] mem_addr;
  logic [31:0] mem_len;
  logic        last;

  modport source (output valid, output tx_byte, output cmd_kind, output mem_addr,
                  output mem_len, output last, input ready);
  modport sink   (input valid, input tx_byte, input cmd_kind, input mem_addr,
                  input mem_len, input last, output ready);
endinterface

// ----- rtl/core/gdbrsp_tx_seq.sv -----
// Reply sequencer: holds one reply code and walks it out one item per cycle
// while out_ch is ready. Depends on gdbrsp_pkg and gdbrsp_out_if.
module gdbrsp_tx_seq
  import gdbrsp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  rsp_req_t       req,
  output logic           idle,
  gdbrsp_out_if.source   out_ch
);

  logic        busy_r, busy_nxt;
  rsp_code_t   code_r, code_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [3:0]  cur_len;
  logic        is_last;
  logic        is_desc;
  logic        fire;

  assign cur_len = reply_len(code_r);
  assign is_last = (idx_r == 3'(cur_len - 4'd1));
  assign is_desc = (code_r == RSP_MEM || code_r == RSP_REG) && (idx_r == 3'd1);
  assign fire    = busy_r && out_ch.ready;
  assign idle    = !busy_r;

  assign out_ch.valid    = busy_r;
  assign out_ch.tx_byte  = reply_byte(code_r, idx_r);
  assign out_ch.last     = is_last;
  assign out_ch.mem_addr = (is_desc && code_r == RSP_MEM) ? addr_r : 32'd0;
  assign out_ch.mem_len  = (is_desc && code_r == RSP_MEM) ? len_r : 32'd0;

  always_comb begin
    out_ch.cmd_kind = KIND_BYTE;
    if (is_desc) begin
      out_ch.cmd_kind = (code_r == RSP_MEM) ? KIND_MEM : KIND_REG;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    code_nxt = code_r;
    idx_nxt  = idx_r;
    addr_nxt = addr_r;
    len_nxt  = len_r;
    if (!busy_r && req.valid) begin
      busy_nxt = 1'b1;
      code_nxt = req.code;
      idx_nxt  = 3'd0;
      addr_nxt = req.addr;
      len_nxt  = req.len;
    end else if (fire) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    code_r <= code_nxt;
    idx_r  <= idx_nxt;
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, idx_r} < cur_len))
    else $error("reply index beyond reply length");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |=> !busy_r)
    else $error("sequencer still busy after final item");

  a_hold_unfired: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ch.ready) |=> (busy_r && $stable(idx_r) && $stable(code_r)))
    else $error("reply advanced without a transaction");

endmodule

// ----- rtl/core/gdb_rsp_packet_receiver.sv -----
// GDB remote-protocol packet receiver: framing, checksum, 'm' parsing, replies.
// Depends on gdbrsp_pkg, gdbrsp_if and gdbrsp_tx_seq.
//
// A byte is parsed from the input register; its first reply item shows in the
// cycle after it is processed. One byte is taken per cycle, but a byte that
// triggers a reply waits there until the sequencer has drained the previous
// reply (1 to 8 items, one per cycle while out_ch is ready).
// Reset (synchronous, active low) empties both stages and waits for '$'.
module gdb_rsp_packet_receiver
  import gdbrsp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  gdbrsp_in_if.sink    in_ch,
  gdbrsp_out_if.source out_ch
);

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        comma_r, comma_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;

  logic        seq_idle;
  rsp_code_t   rsp;
  logic        proc;
  logic [7:0]  dv;
  rsp_req_t    req;

  assign dv = digit_value(in_byte_r);

  // Work out the reply this byte triggers and the parser's next state
  always_comb begin
    rsp       = RSP_NONE;
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    comma_nxt = comma_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    case (phase_r)
      PH_WAIT: begin
        // Packet start: clear everything; ignore line noise otherwise
        if (in_byte_r == CH_DOLLAR) begin
          sum_nxt   = 8'd0;
          count_nxt = 8'd0;
          cmd_nxt   = 8'd0;
          comma_nxt = 1'b0;
          addr_nxt  = 32'd0;
          len_nxt   = 32'd0;
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (in_byte_r == CH_HASH) begin
          phase_nxt = PH_CK_HI;
        end else if (count_r >= 8'(MAX_PAYLOAD)) begin
          // Oversized payload: ack and send an empty reply
          phase_nxt = PH_WAIT;
          rsp       = RSP_EMPTY;
        end else begin
          sum_nxt   = sum_r + in_byte_r;
          count_nxt = count_r + 8'd1;
          if (count_r == 8'd0) begin
            cmd_nxt = in_byte_r;
          end else if (cmd_r == CH_LC_M) begin
            // Address up to the first comma, length for everything after
            if (!comma_r) begin
              if (in_byte_r == CH_COMMA) begin
                comma_nxt = 1'b1;
              end else begin
                addr_nxt = {addr_r[27:0], dv[3:0]};
              end
            end else begin
              len_nxt = {len_r[27:0], dv[3:0]};
            end
          end
        end
      end
      PH_CK_HI: begin
        if (dv != {4'd0, sum_r[7:4]}) begin
          rsp       = RSP_NACK;
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = PH_CK_LO;
        end
      end
      PH_CK_LO: begin
        phase_nxt = PH_WAIT;
        if (dv != {4'd0, sum_r[3:0]}) begin
          rsp = RSP_NACK;
        end else if (cmd_r == CH_QUERY) begin
          rsp = RSP_S09;
        end else if (cmd_r == CH_LC_M) begin
          rsp = RSP_MEM;
        end else if (cmd_r == CH_LC_G) begin
          rsp = RSP_REG;
        end else begin
          rsp = RSP_EMPTY;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
  end

  // Advance the held byte unless its reply would collide with one in flight
  assign proc = in_valid_r && (rsp == RSP_NONE || seq_idle);

  assign in_ch.ready = !in_valid_r || proc;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
      in_byte_nxt  = in_ch.rx_byte;
    end
  end

  always_comb begin
    req.valid = proc && (rsp != RSP_NONE);
    req.code  = rsp;
    req.addr  = addr_r;
    req.len   = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_WAIT;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (proc) begin
        phase_r <= phase_nxt;
      end
    end
    in_byte_r <= in_byte_nxt;
    if (proc) begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      cmd_r   <= cmd_nxt;
      comma_r <= comma_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
    end
  end

  gdbrsp_tx_seq u_tx_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .idle   (seq_idle),
    .out_ch (out_ch)
  );

  a_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> seq_idle)
    else $error("reply issued while sequencer busy");

  a_held_byte_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("held byte lost while stalled");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (count_r <= 8'(MAX_PAYLOAD)))
    else $error("payload count past limit");

endmodule
